@@ src/stch_pkg.sv @@
// Package for the triangle L2 texture stretch block: widths, operation and state codes,
// and the command and status structs between the controller and the datapath.
// It depends on nothing else.
package stch_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int AREA_W    = 48;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W + 1;
  localparam int SQ_W      = 2 * PROD_W + 1;
  localparam int NUM_W     = SQ_W + AREA_W;
  localparam int QUO_W     = 64;
  localparam int SH_W      = SQ_W + QUO_W;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_BIT = 3;
  localparam logic CFG_REG_THR = 1'b0;

  typedef enum logic [3:0] {
    OP_D0, OP_D1, OP_NS0, OP_NS1, OP_NT0, OP_NT1, OP_SQS, OP_SQT, OP_DEN, OP_NUM
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_MUL, ST_RET, ST_DECIDE, ST_DIVINIT, ST_DIV, ST_OUT
  } state_e;

  typedef struct packed {
    logic       store;
    logic [1:0] phase;
    logic       mul_start;
    op_e        op;
    logic [1:0] axis;
    logic       retire;
    logic       decide;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic normal;
    logic out_free;
  } status_t;

endpackage

@@ src/stch_if.sv @@
// Channel interfaces for vertex items and result items.
// They depend on stch_pkg for the field widths.
interface stch_vtx_if;
  import stch_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [COORD_W-1:0] tex_u;
  logic signed [COORD_W-1:0] tex_v;
  logic [AREA_W-1:0]         area_3d;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, area_3d, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, area_3d, output ready);
endinterface

interface stch_res_if;
  import stch_pkg::*;
  logic              valid;
  logic              ready;
  logic [QUO_W-1:0]  stretch;
  logic              infinite;
  logic [AREA_W-1:0] area_2d;
  modport source (output valid, stretch, infinite, area_2d, input ready);
  modport sink (input valid, stretch, infinite, area_2d, output ready);
endinterface

@@ src/stch_ctrl.sv @@
// Controller state machine: vertex phase, operation sequence and divider step count.
// It depends on stch_pkg and drives the datapath through cmd_t.
module stch_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  stch_pkg::status_t status_i,
  output logic              in_ready_o,
  output stch_pkg::cmd_t    cmd_o
);
  import stch_pkg::*;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [1:0]        axis_q, axis_d;
  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_D0;
      axis_q  <= '0;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      axis_q  <= axis_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    axis_d  = axis_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (phase_q >= 2'd2) begin
            phase_d = '0;
            op_d    = OP_D0;
            state_d = ST_START;
          end else begin
            phase_d = phase_q + 2'd1;
          end
        end
      end
      ST_START: state_d = ST_MUL;
      ST_MUL: begin
        if (status_i.mul_done) begin
          state_d = ST_RET;
        end
      end
      ST_RET: begin
        state_d = ST_START;
        case (op_q)
          OP_D1: state_d = ST_DECIDE;
          OP_SQT: begin
            if (axis_q == 2'd2) begin
              op_d = OP_DEN;
            end else begin
              axis_d = axis_q + 2'd1;
              op_d   = OP_NS0;
            end
          end
          OP_NUM: state_d = ST_DIVINIT;
          default: op_d = op_e'(op_q + 4'd1);
        endcase
      end
      ST_DECIDE: begin
        if (status_i.normal) begin
          op_d    = OP_NS0;
          axis_d  = '0;
          state_d = ST_START;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIVINIT: begin
        cnt_d   = '1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = op_q;
    cmd_o.axis  = axis_q;
    cmd_o.phase = phase_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.store = in_valid_i;
      end
      ST_START:   cmd_o.mul_start = 1'b1;
      ST_RET:     cmd_o.retire    = 1'b1;
      ST_DECIDE:  cmd_o.decide    = 1'b1;
      ST_DIVINIT: cmd_o.div_init  = 1'b1;
      ST_DIV:     cmd_o.div_step  = 1'b1;
      ST_OUT:     cmd_o.out_load  = status_i.out_free;
      default:    cmd_o.out_load  = 1'b0;
    endcase
  end

endmodule

@@ src/stch_dp.sv @@
// Datapath: vertex store, bit-serial multiplier, accumulators, special-case decision,
// restoring divider and output register. It depends on stch_pkg and follows cmd_t.
module stch_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  stch_pkg::cmd_t                     cmd_i,
  input  logic signed [stch_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [stch_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [stch_pkg::COORD_W-1:0] pos_z_i,
  input  logic signed [stch_pkg::COORD_W-1:0] tex_u_i,
  input  logic signed [stch_pkg::COORD_W-1:0] tex_v_i,
  input  logic [stch_pkg::AREA_W-1:0]         area_3d_i,
  input  logic [stch_pkg::AREA_W-1:0]         thr_i,
  input  logic                               out_ready_i,
  output stch_pkg::status_t                  status_o,
  output logic                               out_valid_o,
  output logic [stch_pkg::QUO_W-1:0]          stretch_o,
  output logic                               infinite_o,
  output logic [stch_pkg::AREA_W-1:0]         area_2d_o
);
  import stch_pkg::*;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
    sdiff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  function automatic logic [PROD_W-1:0] mag(input logic [PROD_W-1:0] x);
    mag = x[PROD_W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [COORD_W-1:0] pos_q [6];
  logic [COORD_W-1:0] tex_q [4];
  logic [COORD_W-1:0] p2_q [3];
  logic [COORD_W-1:0] u2_q, v2_q;
  logic [AREA_W-1:0]  a3_q;

  logic signed [DIFF_W-1:0] du10, du20, du02, dv20, dv10, dv01, pa, pb;
  logic [PROD_W-1:0] opa, opb, mag_a, mag_b;
  logic [PROD_W-1:0] t_q, d_q, ns_q, nt_q, dm;
  logic [SQ_W-1:0]   n_q, den_q;
  logic [NUM_W-1:0]  ma_q, mp_q, res_s, x_q;
  logic [PROD_W-1:0] mb_q;
  logic              msgn_q;
  logic [SH_W-1:0]   ysh_q;
  logic [QUO_W-1:0]  q_q;
  logic              sat_q, ge;
  logic [PROD_W-1:0] thr_ext, a3_ext;
  logic              below_thr, normal_c, normal_q, inf_q;
  logic [AREA_W-1:0] a2_q;
  logic              out_valid_q;
  logic [QUO_W-1:0]  stretch_q;
  logic              infinite_q;
  logic [AREA_W-1:0] area_2d_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      case (cmd_i.phase)
        2'd0: begin
          pos_q[0] <= pos_x_i;
          pos_q[1] <= pos_y_i;
          pos_q[2] <= pos_z_i;
          tex_q[0] <= tex_u_i;
          tex_q[1] <= tex_v_i;
        end
        2'd1: begin
          pos_q[3] <= pos_x_i;
          pos_q[4] <= pos_y_i;
          pos_q[5] <= pos_z_i;
          tex_q[2] <= tex_u_i;
          tex_q[3] <= tex_v_i;
        end
        default: begin
          p2_q[0] <= pos_x_i;
          p2_q[1] <= pos_y_i;
          p2_q[2] <= pos_z_i;
          u2_q    <= tex_u_i;
          v2_q    <= tex_v_i;
          a3_q    <= area_3d_i;
        end
      endcase
    end
  end

  always_comb begin
    du10 = sdiff(tex_q[2], tex_q[0]);
    du20 = sdiff(u2_q, tex_q[0]);
    du02 = sdiff(tex_q[0], u2_q);
    dv20 = sdiff(v2_q, tex_q[1]);
    dv10 = sdiff(tex_q[3], tex_q[1]);
    dv01 = sdiff(tex_q[1], tex_q[3]);
    case (cmd_i.axis)
      2'd0: begin
        pa = sdiff(pos_q[3], pos_q[0]);
        pb = sdiff(p2_q[0], pos_q[0]);
      end
      2'd1: begin
        pa = sdiff(pos_q[4], pos_q[1]);
        pb = sdiff(p2_q[1], pos_q[1]);
      end
      default: begin
        pa = sdiff(pos_q[5], pos_q[2]);
        pb = sdiff(p2_q[2], pos_q[2]);
      end
    endcase
  end

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.op)
      OP_D0: begin
        opa = PROD_W'(du10);
        opb = PROD_W'(dv20);
      end
      OP_D1: begin
        opa = PROD_W'(du20);
        opb = PROD_W'(dv10);
      end
      OP_NS0: begin
        opa = PROD_W'(pa);
        opb = PROD_W'(dv20);
      end
      OP_NS1: begin
        opa = PROD_W'(pb);
        opb = PROD_W'(dv01);
      end
      OP_NT0: begin
        opa = PROD_W'(pa);
        opb = PROD_W'(du02);
      end
      OP_NT1: begin
        opa = PROD_W'(pb);
        opb = PROD_W'(du10);
      end
      OP_SQS: begin
        opa = ns_q;
        opb = ns_q;
      end
      OP_SQT: begin
        opa = nt_q;
        opb = nt_q;
      end
      OP_DEN: begin
        opa = d_q;
        opb = d_q;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    mag_a = mag(opa);
    mag_b = mag(opb);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mp_q <= '0;
      if (cmd_i.op == OP_NUM) begin
        ma_q   <= NUM_W'(n_q);
        mb_q   <= PROD_W'(a3_q);
        msgn_q <= 1'b0;
      end else begin
        ma_q   <= NUM_W'(mag_a);
        mb_q   <= mag_b;
        msgn_q <= opa[PROD_W-1] ^ opb[PROD_W-1];
      end
    end else if (mb_q != '0) begin
      if (mb_q[0]) begin
        mp_q <= mp_q + ma_q;
      end
      ma_q <= ma_q << 1;
      mb_q <= mb_q >> 1;
    end
  end

  assign res_s = msgn_q ? (~mp_q + 1'b1) : mp_q;
  assign ge    = SH_W'(x_q) >= ysh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.retire) begin
      case (cmd_i.op)
        OP_D0: t_q <= res_s[PROD_W-1:0];
        OP_D1: begin
          d_q <= t_q - res_s[PROD_W-1:0];
          n_q <= '0;
        end
        OP_NS0: ns_q <= res_s[PROD_W-1:0];
        OP_NS1: ns_q <= ns_q + res_s[PROD_W-1:0];
        OP_NT0: nt_q <= res_s[PROD_W-1:0];
        OP_NT1: nt_q <= nt_q + res_s[PROD_W-1:0];
        OP_SQS, OP_SQT: n_q <= n_q + mp_q[SQ_W-1:0];
        OP_DEN: den_q <= {mp_q[SQ_W-2:0], 1'b0};
        default: x_q <= mp_q;
      endcase
    end else if (cmd_i.div_init) begin
      sat_q <= SH_W'(x_q) >= {den_q, {QUO_W{1'b0}}};
      ysh_q <= SH_W'(den_q) << (QUO_W - 1);
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        x_q <= x_q - ysh_q[NUM_W-1:0];
      end
      q_q   <= {q_q[QUO_W-2:0], ge};
      ysh_q <= ysh_q >> 1;
    end
  end

  always_comb begin
    dm        = mag(d_q);
    thr_ext   = PROD_W'(thr_i) << (FRAC_BITS + 1);
    a3_ext    = PROD_W'(a3_q) << FRAC_BITS;
    below_thr = dm <= thr_ext;
    normal_c  = (a3_q != '0) && !(below_thr && (dm < a3_ext)) &&
                !(below_thr && (a3_q <= thr_i));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      if ((dm >> (AREA_W + FRAC_BITS + 1)) != '0) begin
        a2_q <= '1;
      end else begin
        a2_q <= dm[FRAC_BITS+1 +: AREA_W];
      end
      normal_q <= normal_c;
      inf_q    <= (a3_q != '0) && below_thr && (dm < a3_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      stretch_q  <= normal_q ? (sat_q ? '1 : q_q) : {QUO_W{inf_q}};
      infinite_q <= inf_q;
      area_2d_q  <= a2_q;
    end
  end

  assign status_o.mul_done = mb_q == '0;
  assign status_o.normal   = normal_c;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign stretch_o         = stretch_q;
  assign infinite_o        = infinite_q;
  assign area_2d_o         = area_2d_q;

endmodule

@@ src/triangle_l2_texture_stretch.sv @@
// The block takes a triangle as three vertex transactions and returns one result transaction
// per triangle. The third vertex starts a sequence on one bit-serial multiplier that adds
// one partial product per cycle: two products with a second operand of at most 33 bits form
// the parameter area, and when neither special case applies, twelve more of at most 33 bits,
// six squares of at most 66 bits, the squared area of at most 66 bits and the area product of
// at most 48 bits follow, then the restoring divider runs. No vertex is taken while a triangle
// is in progress; a finished result waits in the output register while the next vertices
// come in.
// Depends on stch_pkg, stch_if, stch_ctrl and stch_dp.
module triangle_l2_texture_stretch (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  stch_vtx_if.sink                            vtx_i,
  stch_res_if.source                          res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stch_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [stch_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [stch_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import stch_pkg::*;

  logic [AREA_W-1:0] thr_q;
  cmd_t              cmd;
  status_t           status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && (paddr[CFG_IDX_BIT] == CFG_REG_THR)) begin
      thr_q <= pwdata[AREA_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_IDX_BIT] == CFG_REG_THR) ? CFG_DATA_W'(thr_q) : '0;

  stch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .status_i   (status),
    .in_ready_o (vtx_i.ready),
    .cmd_o      (cmd)
  );

  stch_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pos_x_i     (vtx_i.pos_x),
    .pos_y_i     (vtx_i.pos_y),
    .pos_z_i     (vtx_i.pos_z),
    .tex_u_i     (vtx_i.tex_u),
    .tex_v_i     (vtx_i.tex_v),
    .area_3d_i   (vtx_i.area_3d),
    .thr_i       (thr_q),
    .out_ready_i (res_o.ready),
    .status_o    (status),
    .out_valid_o (res_o.valid),
    .stretch_o   (res_o.stretch),
    .infinite_o  (res_o.infinite),
    .area_2d_o   (res_o.area_2d)
  );

endmodule

@@ src/stch_checker.sv @@
// Port-level assertions for the triangle L2 texture stretch block, with the bind that attaches
// them to the top level. It depends on stch_pkg.
module stch_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [stch_pkg::QUO_W-1:0]      stretch,
  input logic                            infinite,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [stch_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [stch_pkg::CFG_DATA_W-1:0] pwdata,
  input logic [stch_pkg::CFG_DATA_W-1:0] prdata
);
  import stch_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(stretch))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && infinite |-> stretch == '1)
    else $error("infinite result without saturated stretch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[CFG_IDX_BIT] == CFG_REG_THR) |=>
      (paddr[CFG_IDX_BIT] != CFG_REG_THR) ||
      (prdata[AREA_W-1:0] == $past(pwdata[AREA_W-1:0])))
    else $error("threshold read-back mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[CFG_DATA_W-1:AREA_W] == '0)
    else $error("threshold upper bits not zero");

endmodule

bind triangle_l2_texture_stretch stch_checker u_stch_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .stretch   (res_o.stretch),
  .infinite  (res_o.infinite),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
